// File: sv/rtlpm_pkg.sv
package rtlpm_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // Operation codes carried by each transfer.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_FIND   = 2'd3
    } t_opcode;

    // Result status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_BADIDX = 3'd3;
    localparam logic [2:0] ST_BADMET = 3'd4;

    // One route as it sits in the table memory. The prefix length is
    // worked out once when the route is added.
    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
        logic [4:0]  metric;
        logic [5:0]  plen;
    } t_entry;

    // Control from the sequencer to the match unit.
    typedef struct packed {
        logic              clear;
        logic              dv;
        t_opcode           opcode;
        logic [SLOT_W-1:0] idx;
        logic              slot_valid;
    } t_scan_ctl;

    // Count of leading one bits in a mask; stops at the first zero.
    function automatic logic [5:0] lead_ones(input logic [31:0] m);
        logic [5:0] n;
        logic       run;
        n   = '0;
        run = 1'b1;
        for (int i = 31; i >= 0; i--) begin
            if (run && m[i]) begin
                n = n + 6'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

// File: sv/route_table_longest_prefix_match.sv
// Add and failed removes give their result from the evaluate state; a remove
// reads just its one slot, while lookup and find scan all TABLE_SLOTS entries of
// the table memory, which delivers one entry per cycle over a full scan.
// One item is in flight at a time; busy is high until its result is driven.
// Reset (synchronous, active low) empties the table at once; the receiver cannot stall.
module route_table_longest_prefix_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_net_mask,
    input  logic [31:0] i_gateway,
    input  logic [3:0]  i_port_id,
    input  logic [4:0]  i_hop_metric,
    input  logic [3:0]  i_slot_sel,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic [31:0] o_route_subnet,
    output logic [31:0] o_route_mask,
    output logic [31:0] o_route_gateway,
    output logic [3:0]  o_route_port,
    output logic [4:0]  o_route_metric,
    output logic [5:0]  o_match_len
);
    import rtlpm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
        logic [4:0]  metric;
        logic [3:0]  sel;
    } t_req;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    t_state                 r_state, n_state;
    t_req                   r_req;
    logic [SLOT_W-1:0]      r_ptr, n_ptr;
    logic                   r_dv;
    logic [SLOT_W-1:0]      r_didx;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;

    logic        r_done, n_done;
    logic [2:0]  r_status, n_status;
    logic [3:0]  r_slot, n_slot;
    logic [31:0] r_subnet, n_subnet;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_gw, n_gw;
    logic [3:0]  r_port, n_port;
    logic [4:0]  r_metric, n_metric;
    logic [5:0]  r_len, n_len;

    logic              w_accept;
    logic              w_free;
    logic [SLOT_W-1:0] w_free_idx;
    logic              w_sel_bad;
    logic [SLOT_W-1:0] w_sel_idx;
    logic              w_we;
    t_entry            w_wdata;
    t_entry            w_rdata;
    t_scan_ctl         w_ctl;
    logic              w_hit;
    logic [SLOT_W-1:0] w_best_idx;
    t_entry            w_best;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Lowest free slot from the valid bits.
    always_comb begin
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_sel_bad = (int'(r_req.sel) >= TABLE_SLOTS);
    assign w_sel_idx = SLOT_W'(r_req.sel);

    // Route written by an add.
    always_comb begin
        w_wdata.subnet  = r_req.addr;
        w_wdata.mask    = r_req.mask;
        w_wdata.gateway = r_req.gateway;
        w_wdata.port    = r_req.port;
        w_wdata.metric  = r_req.metric;
        w_wdata.plen    = lead_ones(r_req.mask);
    end

    assign w_we = (r_state == S_EVAL) && (r_req.opcode == OP_ADD) &&
                  (r_req.metric != 5'd0) && w_free;

    rtlpm_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_free_idx),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // The match unit sees each read entry in the cycle after its address.
    always_comb begin
        w_ctl.clear      = w_accept;
        w_ctl.dv         = r_dv;
        w_ctl.opcode     = r_req.opcode;
        w_ctl.idx        = r_didx;
        w_ctl.slot_valid = r_valid[r_didx];
    end

    rtlpm_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_addr     (r_req.addr),
        .i_mask     (r_req.mask),
        .i_entry    (w_rdata),
        .o_hit      (w_hit),
        .o_best_idx (w_best_idx),
        .o_best     (w_best)
    );

    // Sequencer and result selection.
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_valid  = r_valid;
        n_done   = 1'b0;
        n_status = ST_OK;
        n_slot   = '0;
        n_subnet = '0;
        n_mask   = '0;
        n_gw     = '0;
        n_port   = '0;
        n_metric = '0;
        n_len    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((t_opcode'(i_opcode) == OP_LOOKUP) ||
                        (t_opcode'(i_opcode) == OP_FIND)) begin
                        n_state = S_SCAN;
                        n_ptr   = '0;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (r_req.opcode == OP_ADD) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_req.metric == 5'd0) begin
                        n_status = ST_BADMET;
                    end else if (!w_free) begin
                        n_status = ST_FULL;
                    end else begin
                        n_valid[w_free_idx] = 1'b1;
                        n_slot   = 4'(w_free_idx);
                        n_subnet = r_req.addr;
                        n_mask   = r_req.mask;
                        n_gw     = r_req.gateway;
                        n_port   = r_req.port;
                        n_metric = r_req.metric;
                    end
                end else if (w_sel_bad) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_BADIDX;
                    n_slot   = r_req.sel;
                end else if (!r_valid[w_sel_idx]) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_NONE;
                    n_slot   = r_req.sel;
                end else begin
                    // Remove reads just the one slot it returns.
                    n_state = S_SCAN;
                    n_ptr   = w_sel_idx;
                end
            end
            S_SCAN: begin
                if ((r_req.opcode == OP_REMOVE) || (r_ptr == LAST_SLOT)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (!w_hit) begin
                    n_status = ST_NONE;
                end else begin
                    n_slot   = 4'(w_best_idx);
                    n_subnet = w_best.subnet;
                    n_mask   = w_best.mask;
                    n_gw     = w_best.gateway;
                    n_port   = w_best.port;
                    n_metric = w_best.metric;
                    if (r_req.opcode == OP_LOOKUP) begin
                        n_len = w_best.plen;
                    end
                    if (r_req.opcode == OP_REMOVE) begin
                        n_valid[w_best_idx] = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dv    <= (r_state == S_SCAN);
            r_done  <= n_done;
        end
    end

    // Request capture, scan pointer and result payload. The opcode is given a
    // known value at reset so the match unit never decodes an unknown code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.opcode <= OP_ADD;
        end else if (w_accept) begin
            r_req.opcode  <= t_opcode'(i_opcode);
            r_req.addr    <= i_dest_addr;
            r_req.mask    <= i_net_mask;
            r_req.gateway <= i_gateway;
            r_req.port    <= i_port_id;
            r_req.metric  <= i_hop_metric;
            r_req.sel     <= i_slot_sel;
        end
        r_ptr    <= n_ptr;
        r_didx   <= r_ptr;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_subnet <= n_subnet;
        r_mask   <= n_mask;
        r_gw     <= n_gw;
        r_port   <= n_port;
        r_metric <= n_metric;
        r_len    <= n_len;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot_out      = r_slot;
    assign o_route_subnet  = r_subnet;
    assign o_route_mask    = r_mask;
    assign o_route_gateway = r_gw;
    assign o_route_port    = r_port;
    assign o_route_metric  = r_metric;
    assign o_match_len     = r_len;

    // Each item gives a single strobe, so two results never come back to back.
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on two consecutive cycles");

    // A prefix length is only reported with a successful lookup.
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_match_len != 6'd0)) |-> (o_status == ST_OK))
        else $error("prefix length reported on a failed result");

    // Table full and invalid metric carry no route.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == ST_FULL) || (o_status == ST_BADMET))) |->
        ((o_slot_out == 4'd0) && (o_route_mask == 32'd0) && (o_route_metric == 5'd0)))
        else $error("failed add returned route fields");

    // The table memory is written only by an add while no scan is running.
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_EVAL) && !r_valid[w_free_idx]))
        else $error("table write outside a free-slot add");

endmodule

// File: sv/rtlpm_mem.sv
module rtlpm_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [rtlpm_pkg::SLOT_W-1:0]  i_waddr,
    input  rtlpm_pkg::t_entry             i_wdata,
    input  logic [rtlpm_pkg::SLOT_W-1:0]  i_raddr,
    output rtlpm_pkg::t_entry             o_rdata
);
    import rtlpm_pkg::*;

    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rtlpm_match.sv
module rtlpm_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtlpm_pkg::t_scan_ctl          i_ctl,
    input  logic [31:0]                   i_addr,
    input  logic [31:0]                   i_mask,
    input  rtlpm_pkg::t_entry             i_entry,
    output logic                          o_hit,
    output logic [rtlpm_pkg::SLOT_W-1:0]  o_best_idx,
    output rtlpm_pkg::t_entry             o_best
);
    import rtlpm_pkg::*;

    logic              r_hit;
    logic [SLOT_W-1:0] r_best_idx;
    t_entry            r_best;
    logic              w_cand;
    logic              w_take;

    // Decide whether the entry read this cycle is a candidate, and whether it
    // beats the best one held so far.
    always_comb begin
        w_cand = 1'b0;
        unique case (i_ctl.opcode)
            OP_LOOKUP: w_cand = ((i_addr & i_entry.mask) == i_entry.subnet);
            OP_FIND:   w_cand = (i_entry.subnet == i_addr) && (i_entry.mask == i_mask);
            OP_REMOVE: w_cand = 1'b1;
            OP_ADD:    w_cand = 1'b0;
        endcase
        w_cand = w_cand && i_ctl.dv && i_ctl.slot_valid;
        // Strictly longer prefixes replace the winner, so ties keep the lowest slot.
        w_take = w_cand && (!r_hit ||
                 ((i_ctl.opcode == OP_LOOKUP) && (i_entry.plen > r_best.plen)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit <= 1'b0;
        end else if (w_take) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best     <= i_entry;
            r_best_idx <= i_ctl.idx;
        end
    end

    assign o_hit      = r_hit;
    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;

endmodule
